// ===== hw/rtl/rlpe_pkg.sv =====
// Package for the RGB LED serial pulse encoder.
// Holds shared constants, command and register codes, and the config and item types.
// Depends on nothing; the register file, input stage, bit engine and top level import it.
package rlpe_pkg;

	// Pixel format.
	localparam int PIXEL_BYTES = 3;
	localparam int COLOR_W     = 8;
	localparam int WORD_W      = 3 * COLOR_W;
	localparam int BITS_LEFT_W = 5;
	localparam logic [BITS_LEFT_W-1:0] LOAD_BITS_LEFT = BITS_LEFT_W'(PIXEL_BYTES * 8 - 1);

	// Timing register width and configuration port layout.
	localparam int TIME_W      = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	// Command codes carried by an input transaction.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [COLOR_W-1:0] BRIGHTNESS_RST = 8'd255;
	localparam logic [TIME_W-1:0]  BIT_PERIOD_RST = 16'd80;
	localparam logic [TIME_W-1:0]  ZERO_HIGH_RST  = 16'd25;
	localparam logic [TIME_W-1:0]  ONE_HIGH_RST   = 16'd53;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [COLOR_W-1:0] brightness;
		logic [TIME_W-1:0]  bit_period;
		logic [TIME_W-1:0]  zero_high;
		logic [TIME_W-1:0]  one_high;
	} cfg_t;

	// An item after the input register: command and scaled GRB word.
	typedef struct packed {
		logic              cmd;
		logic [WORD_W-1:0] word;
	} item_t;

endpackage

// ===== hw/rtl/rlpe_if.sv =====
// Handshake interfaces for the input and result channels of the pulse encoder.
// Depends on nothing; field widths follow the pixel and result formats.
interface rlpe_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, command, red, green, blue, input ready);
	modport sink (input valid, command, red, green, blue, output ready);
endinterface

interface rlpe_out_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic frame_done;

	modport source (output valid, line_level, busy_res, frame_done, input ready);
	modport sink (input valid, line_level, busy_res, frame_done, output ready);
endinterface

// ===== hw/rtl/rlpe_cfg_regs.sv =====
// Configuration register file of the pulse encoder.
// Depends on rlpe_pkg for register codes, reset values and cfg_t.
module rlpe_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rlpe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rlpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output rlpe_pkg::cfg_t                  cfg
);
	import rlpe_pkg::*;

	cfg_t cfg_q;

	// Write one register per transaction; the index selects it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness <= BRIGHTNESS_RST;
			cfg_q.bit_period <= BIT_PERIOD_RST;
			cfg_q.zero_high  <= ZERO_HIGH_RST;
			cfg_q.one_high   <= ONE_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BRIGHTNESS: cfg_q.brightness <= cfg_wdata[COLOR_W-1:0];
				REG_BIT_PERIOD: cfg_q.bit_period <= cfg_wdata[TIME_W-1:0];
				REG_ZERO_HIGH:  cfg_q.zero_high  <= cfg_wdata[TIME_W-1:0];
				REG_ONE_HIGH:   cfg_q.one_high   <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/rlpe_input_stage.sv =====
// Input register of the pulse encoder: scales the colors and reorders them to GRB.
// Depends on rlpe_pkg and the rlpe_in_if interface.
module rlpe_input_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	rlpe_in_if.sink                       in,
	input  logic [rlpe_pkg::COLOR_W-1:0]  brightness,
	output logic                          item_valid,
	output rlpe_pkg::item_t               item,
	input  logic                          item_take
);
	import rlpe_pkg::*;

	logic                 valid_s1;
	item_t                item_s1;
	logic [2*COLOR_W-1:0] red_prod;
	logic [2*COLOR_W-1:0] green_prod;
	logic [2*COLOR_W-1:0] blue_prod;
	logic                 accept;

	// Brightness scaling: keep the upper byte of each 8x8 product.
	always_comb begin
		red_prod   = {{COLOR_W{1'b0}}, in.red} * {{COLOR_W{1'b0}}, brightness};
		green_prod = {{COLOR_W{1'b0}}, in.green} * {{COLOR_W{1'b0}}, brightness};
		blue_prod  = {{COLOR_W{1'b0}}, in.blue} * {{COLOR_W{1'b0}}, brightness};
	end

	// The register may refill in the same cycle it is emptied.
	assign in.ready = !valid_s1 || item_take;
	assign accept   = in.valid && in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd  <= in.command;
			item_s1.word <= {green_prod[2*COLOR_W-1:COLOR_W],
				red_prod[2*COLOR_W-1:COLOR_W],
				blue_prod[2*COLOR_W-1:COLOR_W]};
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ===== hw/rtl/rlpe_bit_engine.sv =====
// Bit timing engine of the pulse encoder: holds the sending state and the result register.
// Depends on rlpe_pkg and the rlpe_out_if interface.
module rlpe_bit_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  rlpe_pkg::cfg_t  cfg,
	input  logic            item_valid,
	input  rlpe_pkg::item_t item,
	output logic            item_take,
	rlpe_out_if.source      out
);
	import rlpe_pkg::*;

	logic [WORD_W-1:0]      pixel_shift_q;
	logic [BITS_LEFT_W-1:0] bits_left_q;
	logic [TIME_W-1:0]      tick_count_q;
	logic                   sending_q;

	logic                   out_valid_q;
	logic                   line_level_q;
	logic                   busy_res_q;
	logic                   frame_done_q;

	logic [TIME_W-1:0]      high_time;
	logic [TIME_W-1:0]      limit;
	logic [TIME_W:0]        tick_next;
	logic                   bit_end;

	logic [WORD_W-1:0]      pixel_shift_d;
	logic [BITS_LEFT_W-1:0] bits_left_d;
	logic [TIME_W-1:0]      tick_count_d;
	logic                   sending_d;
	logic                   line_d;
	logic                   done_d;

	// The result register frees up when empty or when its transaction completes.
	assign item_take = item_valid && (!out_valid_q || out.ready);

	// Bit timing: the bit lasts max(high time, period, 1) ticks.
	always_comb begin
		high_time = pixel_shift_q[WORD_W-1] ? cfg.one_high : cfg.zero_high;
		limit     = (high_time > cfg.bit_period) ? high_time : cfg.bit_period;
		if (limit == '0) begin
			limit = TIME_W'(1);
		end
		tick_next = {1'b0, tick_count_q} + (TIME_W+1)'(1);
		bit_end   = tick_next >= {1'b0, limit};
	end

	// Next state and result for the item in the input register.
	always_comb begin
		pixel_shift_d = pixel_shift_q;
		bits_left_d   = bits_left_q;
		tick_count_d  = tick_count_q;
		sending_d     = sending_q;
		line_d        = 1'b0;
		done_d        = 1'b0;
		if (item.cmd == CMD_LOAD) begin
			// A load while a pixel is going out is dropped.
			if (!sending_q) begin
				pixel_shift_d = item.word;
				bits_left_d   = LOAD_BITS_LEFT;
				tick_count_d  = '0;
				sending_d     = 1'b1;
			end
		end else if (sending_q) begin
			line_d = tick_count_q < high_time;
			if (bit_end) begin
				tick_count_d  = '0;
				pixel_shift_d = {pixel_shift_q[WORD_W-2:0], 1'b0};
				if (bits_left_q == '0) begin
					sending_d = 1'b0;
					done_d    = 1'b1;
				end else begin
					bits_left_d = bits_left_q - BITS_LEFT_W'(1);
				end
			end else begin
				tick_count_d = tick_next[TIME_W-1:0];
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_shift_q <= '0;
			bits_left_q   <= '0;
			tick_count_q  <= '0;
			sending_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (item_take) begin
				pixel_shift_q <= pixel_shift_d;
				bits_left_q   <= bits_left_d;
				tick_count_q  <= tick_count_d;
				sending_q     <= sending_d;
			end
			if (!out_valid_q || out.ready) begin
				out_valid_q <= item_valid;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (item_take) begin
			line_level_q <= line_d;
			busy_res_q   <= sending_d;
			frame_done_q <= done_d;
		end
	end

	assign out.valid      = out_valid_q;
	assign out.line_level = line_level_q;
	assign out.busy_res   = busy_res_q;
	assign out.frame_done = frame_done_q;

endmodule

// ===== hw/rtl/rgb_led_serial_pulse_encoder_unit.sv =====
// Top level of the RGB LED serial pulse encoder.
// Depends on rlpe_pkg, rlpe_if, rlpe_cfg_regs, rlpe_input_stage and rlpe_bit_engine.
//
// The encoder takes one transaction per clock cycle when the result side is not stalled
// and returns exactly one result for each: the item is scaled by the brightness register
// and held in the input register, then the bit timing update runs and loads the result
// register. The update of the bit state (shift word, bits left, tick count) sets the rate.
// A tick transaction advances the pulse timing by one tick; a load transaction starts a new
// GRB pixel unless one is still being sent, in which case it is dropped. Configuration
// registers are written through the plain write port and should only change while no
// transaction is in flight.
module rgb_led_serial_pulse_encoder_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rlpe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rlpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	rlpe_in_if.sink                          in,
	rlpe_out_if.source                       out
);
	import rlpe_pkg::*;

	cfg_t  cfg;
	logic  item_valid;
	item_t item;
	logic  item_take;

	// Configuration registers.
	rlpe_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register with color scaling.
	rlpe_input_stage u_input_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in         (in),
		.brightness (cfg.brightness),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	// Bit timing and result register.
	rlpe_bit_engine u_bit_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.out        (out)
	);

endmodule

// ===== hw/rtl/rlpe_checker.sv =====
// Port-level checker for the pulse encoder, bound to the top level.
// Depends only on the top level's clock, reset and result channel ports.
module rlpe_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic line_level,
	input logic busy_res,
	input logic frame_done
);

	// A stalled result stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(line_level) && $stable(busy_res) && $stable(frame_done))
		else $error("result payload changed while stalled");

	// The end of a frame leaves the encoder idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> !busy_res)
		else $error("frame done reported while still busy");

	// A high line outside the last bit end means a pixel is still going out.
	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_level && !frame_done |-> busy_res)
		else $error("line driven high while idle");

endmodule

bind rgb_led_serial_pulse_encoder_unit rlpe_checker u_rlpe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out.valid),
	.out_ready  (out.ready),
	.line_level (out.line_level),
	.busy_res   (out.busy_res),
	.frame_done (out.frame_done)
);
